>>> hw/rtl/ndc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_pkg: shared definitions for the number to digit codes core
// Widths, format and pad codes, character code bases, the per-cell control
// group and the digit to character code mapping.
// ----------------------------------------------------------------------------
package ndc_pkg;

    localparam int CELL_COUNT = 10;  // decimal positions, units first
    localparam int HEX_CELLS  = 8;   // hexadecimal positions
    localparam int VALUE_W    = 33;
    localparam int CODE_W     = 16;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = 4;
    localparam int BIT_CNT_W  = 6;

    // Format requests. Code three behaves as hexadecimal.
    localparam logic [1:0] CMD_SIGNED   = 2'd0;
    localparam logic [1:0] CMD_UNSIGNED = 2'd1;
    localparam logic [1:0] CMD_HEX      = 2'd2;

    // Pad modes. Code three behaves as left aligned.
    localparam logic [1:0] PAD_ZERO  = 2'd0;
    localparam logic [1:0] PAD_SPACE = 2'd1;
    localparam logic [1:0] PAD_LEFT  = 2'd2;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX_HEX = 4'd15;

    // Character codes, full width and half width.
    localparam logic [CODE_W-1:0] CODE_DIGIT_FW  = 16'hFF10;
    localparam logic [CODE_W-1:0] CODE_DIGIT_HW  = 16'h0030;
    localparam logic [CODE_W-1:0] CODE_LETTER_FW = 16'hFF21;
    localparam logic [CODE_W-1:0] CODE_LETTER_HW = 16'h0041;
    localparam logic [CODE_W-1:0] CODE_MINUS_FW  = 16'h30FC;
    localparam logic [CODE_W-1:0] CODE_MINUS_HW  = 16'h002D;
    localparam logic [CODE_W-1:0] CODE_SPACE_FW  = 16'h3000;
    localparam logic [CODE_W-1:0] CODE_SPACE_HW  = 16'h0020;
    localparam logic [CODE_W-1:0] CODE_QUEST_FW  = 16'hFF1F;
    localparam logic [CODE_W-1:0] CODE_QUEST_HW  = 16'h003F;

    typedef struct packed {
        logic load;   // take the parallel load digit
        logic shift;  // one double-dabble step: adjust, then shift in a bit
    } cell_ctrl_t;

    function automatic logic [CODE_W-1:0] digit_code(input logic [DIGIT_W-1:0] d,
                                                     input logic full);
        logic [CODE_W-1:0] code;
        if (d < 4'd10) begin
            code = (full ? CODE_DIGIT_FW : CODE_DIGIT_HW) + {12'd0, d};
        end else begin
            code = (full ? CODE_LETTER_FW : CODE_LETTER_HW) + {12'd0, d - 4'd10};
        end
        return code;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ndc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_cell: one digit cell of the conversion row
// Holds one 4-bit digit. A shift step adds three to a digit of five or more,
// passes the adjusted top bit to the next cell and takes the bit handed up
// by the cell below.
// ----------------------------------------------------------------------------
module ndc_cell
    import ndc_pkg::*;
(
    input  wire logic               aclk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [DIGIT_W-1:0] load_digit,
    input  wire logic               carry_in,
    output logic                    carry_out,
    output logic [DIGIT_W-1:0]      digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adjusted;

    // The adjusted digit depends on this cell's register only, so the carry
    // chain does not ripple combinationally across the row.
    assign adjusted  = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adjusted[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.load) begin
            digit_next = load_digit;
        end else if (ctrl.shift) begin
            digit_next = {adjusted[DIGIT_W-2:0], carry_in};
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/number_to_digit_codes_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_digit_codes_core: number to character code run converter
// Turns one number and its format request into a run of 16-bit character
// codes, most significant position first, through a row of digit cells.
// ----------------------------------------------------------------------------
// Usage. The input channel (s_*) takes one item: a format command, a 33-bit
// value, a digit count, a pad mode and a width select. The result channel
// (m_*) then delivers one item per character code: an optional minus code,
// then the digit positions, each either a digit, a letter, a space or a
// question mark. m_last is high on the units digit, which ends the run.
// Timing. Decimal items load the magnitude into a shift register and run
// 33 double-dabble steps through a row of ten digit cells, one bit per
// cycle. Hexadecimal items load their nibbles straight into the cells.
// After that, one position is handled per cycle while the output register
// is free; a negative decimal item first emits its minus code. Dropped
// leading zeros in left-aligned mode are still handled as positions and
// also wait for a free output register. A new item is taken once the
// previous run has been handed to the output register, even if its last
// code is still waiting.
// Reset clears the sequencer and the output valid; no codes are pending
// afterwards. When the receiver holds m_ready low, the current code stays
// in the output register and the sequencer waits; nothing is lost.
// ----------------------------------------------------------------------------
module number_to_digit_codes_core
    import ndc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_command,
    input  wire logic signed [VALUE_W-1:0] s_value,
    input  wire logic [3:0]           s_digit_count,
    input  wire logic [1:0]           s_pad_mode,
    input  wire logic                 s_full_width,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CODE_W-1:0]         m_char_code,
    output logic                      m_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [BIT_CNT_W-1:0] LAST_STEP = BIT_CNT_W'(VALUE_W - 1);

    // Sequencer state.
    logic [1:0]           state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BIT_CNT_W-1:0] step_reg, step_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     top_reg, top_next;
    logic                 hex_reg, hex_next;
    logic                 full_reg, full_next;
    logic [1:0]           pad_reg, pad_next;
    logic                 neg_reg, neg_next;
    logic                 supp_reg, supp_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]    m_char_code_reg, m_char_code_next;
    logic                 m_last_reg, m_last_next;

    // Cell row.
    cell_ctrl_t           cell_ctrl;
    logic [DIGIT_W-1:0]   load_digit [CELL_COUNT];
    logic [DIGIT_W-1:0]   digit_w    [CELL_COUNT];
    logic                 carry_w    [CELL_COUNT];

    logic                 accept;
    logic                 out_free;
    logic                 in_hex;
    logic                 in_neg;
    logic [3:0]           cnt_clamped;
    logic [VALUE_W-1:0]   raw;
    logic [VALUE_W-1:0]   magnitude;
    logic                 over;
    logic [DIGIT_W-1:0]   cur_digit;
    logic                 is_quest;
    logic                 units;
    logic                 shows;

    assign raw      = s_value;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_hex   = s_command[1];
    assign in_neg   = (s_command == CMD_SIGNED) && raw[VALUE_W-1];

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last      = m_last_reg;

    // A zero count means one position; decimal saturates at ten, hex at eight.
    always_comb begin
        cnt_clamped = (s_digit_count == 4'd0) ? 4'd1 : s_digit_count;
        if (in_hex && cnt_clamped > 4'(HEX_CELLS)) begin
            cnt_clamped = 4'(HEX_CELLS);
        end else if (!in_hex && cnt_clamped > 4'(CELL_COUNT)) begin
            cnt_clamped = 4'(CELL_COUNT);
        end
    end

    // Signed requests convert the full 33-bit magnitude; other requests use
    // the low 32 bits as an unsigned number.
    always_comb begin
        if (s_command == CMD_SIGNED) begin
            magnitude = in_neg ? (~raw + VALUE_W'(1)) : raw;
        end else begin
            magnitude = {1'b0, raw[VALUE_W-2:0]};
        end
    end

    always_comb begin
        cell_ctrl.load  = accept;
        cell_ctrl.shift = (state_reg == ST_CONV);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CELL_COUNT; gi++) begin : g_cell
            logic cin;
            if (gi < HEX_CELLS) begin : g_hex_load
                assign load_digit[gi] = in_hex ? raw[gi*DIGIT_W +: DIGIT_W] : '0;
            end else begin : g_zero_load
                assign load_digit[gi] = '0;
            end
            if (gi == 0) begin : g_first
                assign cin = bin_reg[VALUE_W-1];
            end else begin : g_next
                assign cin = carry_w[gi-1];
            end
            ndc_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .load_digit (load_digit[gi]),
                .carry_in   (cin),
                .carry_out  (carry_w[gi]),
                .digit      (digit_w[gi])
            );
        end
    endgenerate

    // The top position overflows when any digit above it is nonzero.
    always_comb begin
        over = 1'b0;
        for (int i = 0; i < CELL_COUNT; i++) begin
            if (POS_W'(i) > top_reg && digit_w[i] != '0) begin
                over = 1'b1;
            end
        end
    end

    always_comb begin
        units     = (pos_reg == '0);
        cur_digit = digit_w[pos_reg];
        is_quest  = 1'b0;
        if (pos_reg == top_reg && over) begin
            if (hex_reg) begin
                cur_digit = DIGIT_MAX_HEX;
            end else begin
                is_quest = 1'b1;
            end
        end
        shows = !supp_reg || cur_digit != '0 || is_quest || units;
    end

    always_comb begin
        state_next       = state_reg;
        bin_next         = bin_reg;
        step_next        = step_reg;
        pos_next         = pos_reg;
        top_next         = top_reg;
        hex_next         = hex_reg;
        full_next        = full_reg;
        pad_next         = pad_reg;
        neg_next         = neg_reg;
        supp_next        = supp_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_char_code_next = m_char_code_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    bin_next  = magnitude;
                    step_next = '0;
                    top_next  = cnt_clamped - 4'd1;
                    pos_next  = cnt_clamped - 4'd1;
                    hex_next  = in_hex;
                    full_next = s_full_width;
                    pad_next  = s_pad_mode;
                    neg_next  = in_neg;
                    supp_next = (s_pad_mode != PAD_ZERO);
                    state_next = in_hex ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV: begin
                bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg + BIT_CNT_W'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = full_reg ? CODE_MINUS_FW : CODE_MINUS_HW;
                    m_last_next      = 1'b0;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (shows) begin
                        supp_next    = 1'b0;
                        m_valid_next = 1'b1;
                        m_last_next  = units;
                        if (is_quest) begin
                            m_char_code_next = full_reg ? CODE_QUEST_FW : CODE_QUEST_HW;
                        end else begin
                            m_char_code_next = digit_code(cur_digit, full_reg);
                        end
                    end else if (pad_reg == PAD_SPACE) begin
                        m_valid_next     = 1'b1;
                        m_last_next      = 1'b0;
                        m_char_code_next = full_reg ? CODE_SPACE_FW : CODE_SPACE_HW;
                    end
                    if (units) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg - 4'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg         <= bin_next;
        step_reg        <= step_next;
        pos_reg         <= pos_next;
        top_reg         <= top_next;
        hex_reg         <= hex_next;
        full_reg        <= full_next;
        pad_reg         <= pad_next;
        neg_reg         <= neg_next;
        supp_reg        <= supp_next;
        m_char_code_reg <= m_char_code_next;
        m_last_reg      <= m_last_next;
    end

endmodule
`default_nettype wire
